@@ rtl/mpb_pkg.sv @@
// Shared types and constants for the multi-panel playback barrier.
// No dependencies; mpb_ctrl, mpb_dp, the top level and the checker import this package.

package mpb_pkg;

    localparam int MPB_PANELS = 16;
    localparam int POS_W      = 32;
    localparam int JC_W       = 5;

    // Item kinds
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_REPORT   = 3'd1;
    localparam logic [2:0] KIND_SOURCES  = 3'd2;
    localparam logic [2:0] KIND_POSITION = 3'd3;
    localparam logic [2:0] KIND_RESET    = 3'd4;

    // Panel status codes
    localparam logic [2:0] PS_UPDATING   = 3'd1;
    localparam logic [2:0] PS_UPDATED    = 3'd2;
    localparam logic [2:0] PS_PRESENTING = 3'd3;
    localparam logic [2:0] PS_PRESENTED  = 3'd4;

    localparam logic [JC_W-1:0] JC_MAX = 5'd31;

    typedef enum logic [2:0] {
        CS_IDLE       = 3'd0,
        CS_NORMAL     = 3'd1,
        CS_UPDATING   = 3'd2,
        CS_UPDATED    = 3'd3,
        CS_PRESENTING = 3'd4,
        CS_PRESENTED  = 3'd5
    } cs_t;

    // Operation applied to each panel during a walk
    typedef enum logic [2:0] {
        OP_JOIN     = 3'd0,
        OP_SET_UPD  = 3'd1,
        OP_SET_PRES = 3'd2,
        OP_SCAN     = 3'd3,
        OP_LAG      = 3'd4,
        OP_CNT_PRES = 3'd5
    } op_t;

    // One panel record as held in the panel RAM
    typedef struct packed {
        logic             working;
        logic [2:0]       st;
        logic [7:0]       src;
        logic [POS_W-1:0] pos;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic item_rd;
        logic item_wr;
        logic walk;
        logic acc_clr;
        logic clear;
        logic cs_we;
        cs_t  cs_val;
        logic join_we;
        logic out_load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       ok;
        cs_t        cs;
        logic       walk_last;
        logic       acc_nz;
        logic       cnt_eq_join;
        logic       sync_hit;
        logic       out_free;
    } sts_t;

endpackage

@@ rtl/mpb_req_if.sv @@
// Input item channel of the playback barrier: valid/ready plus item fields.
// No dependencies.

interface mpb_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [3:0]        panel;
    logic [2:0]        reported_status;
    logic [7:0]        source_count;
    logic signed [4:0] source_index;
    logic [31:0]       position;

    modport source (output valid, kind, panel, reported_status, source_count,
                    source_index, position, input ready);
    modport sink   (input valid, kind, panel, reported_status, source_count,
                    source_index, position, output ready);
endinterface

@@ rtl/mpb_rsp_if.sv @@
// Result item channel of the playback barrier: valid/ready plus result fields.
// No dependencies.

interface mpb_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] controller_status;
    logic [2:0] panel_status;
    logic [4:0] joined_count;

    modport source (output valid, controller_status, panel_status, joined_count,
                    input ready);
    modport sink   (input valid, controller_status, panel_status, joined_count,
                    output ready);
endinterface

@@ rtl/mpb_cfg_if.sv @@
// Configuration write channel carrying the sync window register.
// No dependencies.

interface mpb_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/mpb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mpb_ctrl.sv @@
// Sequencer of the playback barrier: decodes items and steps the datapath.
// Depends on mpb_pkg (cmd_t, sts_t, codes).

module mpb_ctrl
    import mpb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DISPATCH = 9'b000000010,
        ST_RD       = 9'b000000100,
        ST_MOD      = 9'b000001000,
        ST_WALK     = 9'b000010000,
        ST_DRAIN    = 9'b000100000,
        ST_FIN      = 9'b001000000,
        ST_FETCH    = 9'b010000000,
        ST_LOAD     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_JOIN;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.cs_val = CS_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.acc_clr = 1'b1;
                state_next  = ST_FETCH;
                unique case (sts.kind)
                    KIND_TICK:
                    begin
                        unique case (sts.cs)
                            CS_IDLE:
                            begin
                                op_next    = OP_JOIN;
                                state_next = ST_WALK;
                            end
                            CS_NORMAL:
                            begin
                                op_next    = OP_SET_UPD;
                                state_next = ST_WALK;
                            end
                            CS_UPDATING:
                            begin
                                op_next    = OP_SCAN;
                                state_next = ST_WALK;
                            end
                            CS_UPDATED:
                            begin
                                op_next    = OP_SET_PRES;
                                state_next = ST_WALK;
                            end
                            CS_PRESENTING:
                            begin
                                op_next    = OP_CNT_PRES;
                                state_next = ST_WALK;
                            end
                            CS_PRESENTED:
                            begin
                                cmd.cs_we  = 1'b1;
                                cmd.cs_val = CS_IDLE;
                            end
                            default: ;
                        endcase
                    end
                    KIND_REPORT, KIND_SOURCES, KIND_POSITION:
                    begin
                        if (sts.ok)
                        begin
                            state_next = ST_RD;
                        end
                    end
                    KIND_RESET:
                    begin
                        cmd.clear = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_RD:
            begin
                cmd.item_rd = 1'b1;
                state_next  = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.item_wr = 1'b1;
                state_next  = ST_FETCH;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_FETCH;
                unique case (op_reg)
                    OP_JOIN:
                    begin
                        cmd.join_we = 1'b1;
                        if (sts.acc_nz)
                        begin
                            cmd.cs_we  = 1'b1;
                            cmd.cs_val = CS_NORMAL;
                        end
                    end
                    OP_SET_UPD:
                    begin
                        cmd.cs_we  = 1'b1;
                        cmd.cs_val = CS_UPDATING;
                    end
                    OP_SET_PRES:
                    begin
                        cmd.cs_we  = 1'b1;
                        cmd.cs_val = CS_PRESENTING;
                    end
                    OP_CNT_PRES:
                    begin
                        if (sts.cnt_eq_join)
                        begin
                            cmd.cs_we  = 1'b1;
                            cmd.cs_val = CS_PRESENTED;
                        end
                    end
                    OP_SCAN:
                    begin
                        // all joined panels updated: accept, or send laggards back
                        if (sts.cnt_eq_join)
                        begin
                            if (sts.sync_hit)
                            begin
                                cmd.cs_we  = 1'b1;
                                cmd.cs_val = CS_UPDATED;
                            end
                            else
                            begin
                                op_next    = OP_LAG;
                                state_next = ST_WALK;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_FETCH:
            begin
                cmd.item_rd = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mpb_dp.sv @@
// Datapath of the playback barrier: item and window registers, panel RAM,
// walk pipeline, accumulators and result register. Depends on mpb_pkg, mpb_ram.

module mpb_dp
    import mpb_pkg::*;
#(
    parameter int PANELS = MPB_PANELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [2:0]        kind,
    input  logic [3:0]        panel,
    input  logic [2:0]        reported_status,
    input  logic [7:0]        source_count,
    input  logic signed [4:0] source_index,
    input  logic [31:0]       position,
    input  logic              cfg_valid,
    input  logic [31:0]       cfg_data,
    input  logic              rsp_ready,
    output logic              out_valid,
    output logic [2:0]        out_cs,
    output logic [2:0]        out_ps,
    output logic [JC_W-1:0]   out_jc
);

    localparam int AW = (PANELS > 1) ? $clog2(PANELS) : 1;
    localparam int CW = $clog2(PANELS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(PANELS - 1);

    // item
    logic [2:0]        kind_reg;
    logic [3:0]        panel_reg;
    logic [2:0]        rep_reg;
    logic [7:0]        cnt_reg;
    logic signed [4:0] slot_reg;
    logic [31:0]       pos_reg;

    logic [31:0]       win_reg;
    cs_t               cs_reg, cs_next;
    logic [CW-1:0]     join_reg, join_next;
    logic [PANELS-1:0] valid_reg, valid_next;

    logic [AW-1:0]     walk_idx_reg, walk_idx_next;
    logic [AW-1:0]     rd_addr_q_reg;
    logic              proc_vld_reg;
    logic [AW-1:0]     proc_idx_reg;

    logic [CW-1:0]     acc_reg, acc_next;
    logic [CW-1:0]     same_reg, same_next;
    logic              seen_reg, seen_next;
    logic [POS_W-1:0]  ref_reg, ref_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;

    logic              out_valid_reg;
    logic [2:0]        out_cs_reg;
    logic [2:0]        out_ps_reg;
    logic [JC_W-1:0]   out_jc_reg;

    logic              ok;
    logic [AW-1:0]     panel_addr;
    logic              ram_re, ram_we;
    logic [AW-1:0]     ram_raddr, ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            ent, walk_upd, item_upd, wr_ent;
    logic              walk_wr, cnt_inc, stat;

    assign ok         = (32'(panel_reg) < PANELS);
    assign panel_addr = AW'(panel_reg);

    assign ram_re    = cmd.walk | cmd.item_rd;
    assign ram_raddr = cmd.walk ? walk_idx_reg : panel_addr;
    assign ram_we    = (proc_vld_reg & walk_wr) | cmd.item_wr;
    assign ram_waddr = cmd.item_wr ? panel_addr : proc_idx_reg;
    assign wr_ent    = cmd.item_wr ? item_upd : walk_upd;

    mpb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PANELS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_ent),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // an entry never written since reset reads as all zero
    assign ent = valid_reg[rd_addr_q_reg] ? entry_t'(ram_rdata) : '0;

    always_comb
    begin
        walk_upd = ent;
        walk_wr  = 1'b0;
        cnt_inc  = 1'b0;
        stat     = 1'b0;
        unique case (cmd.op)
            OP_JOIN:
            begin
                walk_wr = 1'b1;
                if (ent.src != 8'd0)
                begin
                    walk_upd.working = 1'b1;
                    cnt_inc          = 1'b1;
                end
            end
            OP_SET_UPD:
            begin
                walk_wr = 1'b1;
                if (ent.working)
                begin
                    walk_upd.st = PS_UPDATING;
                end
            end
            OP_SET_PRES:
            begin
                walk_wr = 1'b1;
                if (ent.working)
                begin
                    walk_upd.st = PS_PRESENTING;
                end
            end
            OP_SCAN:
            begin
                stat    = ent.working;
                cnt_inc = ent.working & (ent.st == PS_UPDATED);
            end
            OP_LAG:
            begin
                walk_wr = 1'b1;
                if (ent.working && (ent.pos < hi_reg))
                begin
                    walk_upd.st = PS_UPDATING;
                end
            end
            OP_CNT_PRES:
            begin
                cnt_inc = ent.working & (ent.st == PS_PRESENTED);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        item_upd = ent;
        unique case (kind_reg)
            KIND_REPORT:
            begin
                if (rep_reg == PS_UPDATED && ent.st == PS_UPDATING)
                begin
                    item_upd.st = PS_UPDATED;
                end
                else if (rep_reg == PS_PRESENTED && ent.st == PS_PRESENTING)
                begin
                    item_upd.st = PS_PRESENTED;
                end
            end
            KIND_SOURCES:
            begin
                item_upd.src = cnt_reg;
            end
            KIND_POSITION:
            begin
                if (slot_reg == 5'sd0 && ent.st == PS_UPDATING)
                begin
                    item_upd.pos = pos_reg;
                end
            end
            default: ;
        endcase
    end

    // accumulators over one walk
    always_comb
    begin
        acc_next  = acc_reg;
        same_next = same_reg;
        seen_next = seen_reg;
        ref_next  = ref_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        if (cmd.acc_clr)
        begin
            acc_next  = '0;
            same_next = '0;
            seen_next = 1'b0;
            ref_next  = '0;
            lo_next   = '0;
            hi_next   = '0;
        end
        else if (proc_vld_reg)
        begin
            if (cnt_inc)
            begin
                acc_next = CW'(acc_reg + 1'b1);
            end
            if (stat)
            begin
                if (!seen_reg)
                begin
                    seen_next = 1'b1;
                    ref_next  = ent.pos;
                    lo_next   = ent.pos;
                    hi_next   = ent.pos;
                    same_next = CW'(same_reg + 1'b1);
                end
                else if (ent.pos == ref_reg)
                begin
                    same_next = CW'(same_reg + 1'b1);
                end
                else
                begin
                    if (ent.pos < lo_reg)
                    begin
                        lo_next = ent.pos;
                    end
                    if (ent.pos > hi_reg)
                    begin
                        hi_next = ent.pos;
                    end
                end
            end
        end
    end

    always_comb
    begin
        cs_next    = cs_reg;
        join_next  = join_reg;
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            cs_next    = CS_IDLE;
            join_next  = '0;
            valid_next = '0;
        end
        else
        begin
            if (cmd.cs_we)
            begin
                cs_next = cmd.cs_val;
            end
            if (cmd.join_we)
            begin
                join_next = acc_reg;
            end
            if (ram_we)
            begin
                valid_next[ram_waddr] = 1'b1;
            end
        end
    end

    always_comb
    begin
        walk_idx_next = walk_idx_reg;
        if (cmd.walk)
        begin
            walk_idx_next = (walk_idx_reg == LAST_IDX) ? '0 : AW'(walk_idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= 32'd65536;
            cs_reg        <= CS_IDLE;
            join_reg      <= '0;
            valid_reg     <= '0;
            walk_idx_reg  <= '0;
            proc_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                win_reg <= cfg_data;
            end
            cs_reg       <= cs_next;
            join_reg     <= join_next;
            valid_reg    <= valid_next;
            walk_idx_reg <= walk_idx_next;
            proc_vld_reg <= cmd.walk;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            panel_reg <= panel;
            rep_reg   <= reported_status;
            cnt_reg   <= source_count;
            slot_reg  <= source_index;
            pos_reg   <= position;
        end
        if (ram_re)
        begin
            rd_addr_q_reg <= ram_raddr;
        end
        proc_idx_reg <= walk_idx_reg;
        acc_reg      <= acc_next;
        same_reg     <= same_next;
        seen_reg     <= seen_next;
        ref_reg      <= ref_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        if (cmd.out_load)
        begin
            out_cs_reg <= cs_reg;
            out_ps_reg <= ok ? ent.st : 3'd0;
            out_jc_reg <= (32'(join_reg) > 32'd31) ? JC_MAX : JC_W'(join_reg);
        end
    end

    assign sts.kind        = kind_reg;
    assign sts.ok          = ok;
    assign sts.cs          = cs_reg;
    assign sts.walk_last   = (walk_idx_reg == LAST_IDX);
    assign sts.acc_nz      = (acc_reg != '0);
    assign sts.cnt_eq_join = (acc_reg == join_reg);
    assign sts.sync_hit    = (same_reg == join_reg) ||
                             ({1'b0, hi_reg} > ({1'b0, lo_reg} + {1'b0, win_reg}));
    assign sts.out_free    = ~out_valid_reg | rsp_ready;

    assign out_valid = out_valid_reg;
    assign out_cs    = out_cs_reg;
    assign out_ps    = out_ps_reg;
    assign out_jc    = out_jc_reg;

endmodule

@@ rtl/multi_panel_playback_barrier.sv @@
// Top level of the multi-panel playback barrier: sequencer plus datapath.
// Depends on mpb_pkg, the three channel interfaces, mpb_ctrl and mpb_dp.

// Keeps up to PANELS panels in step. Every item gives exactly one result.
// Panel records sit in a RAM with one read and one write port, so a tick
// walks the panels one per cycle, but a tick in presented only returns to idle;
// it walks them again when a position compare sends laggards back to updating.
// Status reports, source counts and positions rewrite the record of a panel in range.
// One item is in work at a time; a new item is taken as soon as the
// previous one has its result registered, even if that result is unread.
// The sync window register may be written at any time and resets to 1.0 s.

module multi_panel_playback_barrier
    import mpb_pkg::*;
#(
    parameter int PANELS = MPB_PANELS
) (
    input logic        clk,
    input logic        rst_n,
    mpb_req_if.sink    req,
    mpb_rsp_if.source  rsp,
    mpb_cfg_if.sink    cfg
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    mpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mpb_dp #(
        .PANELS (PANELS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .kind            (req.kind),
        .panel           (req.panel),
        .reported_status (req.reported_status),
        .source_count    (req.source_count),
        .source_index    (req.source_index),
        .position        (req.position),
        .cfg_valid       (cfg.valid),
        .cfg_data        (cfg.data),
        .rsp_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_cs          (rsp.controller_status),
        .out_ps          (rsp.panel_status),
        .out_jc          (rsp.joined_count)
    );

endmodule

@@ rtl/mpb_checker.sv @@
// Port-level assertions for the playback barrier, bound to the top level.
// Depends on mpb_pkg, multi_panel_playback_barrier and its channel interfaces.

module mpb_checker
    import mpb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] controller_status,
    input logic [2:0] panel_status,
    input logic [4:0] joined_count
);

    // one item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while another is in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(controller_status)
            && $stable(panel_status) && $stable(joined_count))
        else $error("stalled result changed");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> controller_status <= CS_PRESENTED && panel_status <= PS_PRESENTED)
        else $error("status code out of range");

    // normal is only reached with at least one panel joined
    a_normal_joined: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && controller_status == CS_NORMAL |-> joined_count != 5'd0)
        else $error("normal with no joined panel");

endmodule

bind multi_panel_playback_barrier mpb_checker u_mpb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .controller_status (rsp.controller_status),
    .panel_status      (rsp.panel_status),
    .joined_count      (rsp.joined_count)
);
